// ----- hdl/erv_pkg.sv -----
// ---------------------------------------------------------------------------
// erv_pkg
// Shared constants, types and tables for the Euler-angle vector rotator.
// ---------------------------------------------------------------------------
package erv_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int VALUE_WIDTH_DEF       = 32;

    localparam int ANGLE_W = 16;
    localparam int VEC_W   = 32;
    // angle accumulator, 30 fraction bits
    localparam int ZW      = 35;
    // coefficient by vector product, rounded, and the row sum
    localparam int PW      = 34;
    localparam int SW      = 36;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic [63:0]          GAIN_Q46    = 64'd42731626434776;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [VEC_W-1:0] vz;
        logic                    mode;
    } side_t;

    // cordic gain rounded from 46 to f fraction bits, half away from zero
    function automatic logic [63:0] gain_init(input int f);
        logic [63:0] r;
        int          sh;
        sh = 46 - f;
        if (sh == 0)
            r = GAIN_Q46;
        else
            r = (GAIN_Q46 + (64'd1 << (sh - 1))) >> sh;
        return r;
    endfunction

    // atan(2^-i), 30 fraction bits
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 35'sd843314857;
            1:       r = 35'sd497837829;
            2:       r = 35'sd263043837;
            3:       r = 35'sd133525159;
            4:       r = 35'sd67021687;
            5:       r = 35'sd33543516;
            6:       r = 35'sd16775851;
            7:       r = 35'sd8388437;
            8:       r = 35'sd4194283;
            9:       r = 35'sd2097149;
            default: r = ZW'(35'sd1073741824 >>> i);
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/euler_rotate_vector3_unit.sv -----
// ---------------------------------------------------------------------------
// euler_rotate_vector3_unit
// Rotates a Q16.16 3-vector by roll, pitch and yaw (Q3.13 radians).
//
// channel  dir  fields (lowest bit up)
// s_       in   tdata: vec_x, vec_y, vec_z, roll, pitch, yaw; tuser: mode
// m_       out  tdata: out_x, out_y, out_z
//
// one beat per cycle sustained while m_tready is high; a fold stage and
// one cordic micro-rotation per stage, then four matrix and product stages
// rst_n clears all stage valid bits only; data registers are not reset
// each stage holds its beat while the one after it is full and stalled,
// so bubbles close up and nothing is lost or repeated
// ---------------------------------------------------------------------------
module euler_rotate_vector3_unit #(
    parameter int CORDIC_ITERATIONS = erv_pkg::CORDIC_ITERATIONS_DEF,
    parameter int VALUE_WIDTH       = erv_pkg::VALUE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // vec_x, vec_y, vec_z, roll, pitch, yaw
    input  logic [0:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata    // out_x, out_y, out_z
);

    logic                              cor_valid, cor_ready;
    logic [2:0][VALUE_WIDTH-1:0]       cor_sin, cor_cos;
    erv_pkg::side_t                    cor_side, in_side;
    logic                              mat_valid, mat_ready;
    logic [8:0][VALUE_WIDTH-1:0]       mat_m;
    erv_pkg::side_t                    mat_side;
    logic [2:0][erv_pkg::VEC_W-1:0]    res;
    logic [2:0][erv_pkg::ANGLE_W-1:0]  angle;

    assign in_side.vx   = $signed(s_tdata[31:0]);
    assign in_side.vy   = $signed(s_tdata[63:32]);
    assign in_side.vz   = $signed(s_tdata[95:64]);
    assign in_side.mode = s_tuser[0];
    assign angle[0]     = s_tdata[111:96];
    assign angle[1]     = s_tdata[127:112];
    assign angle[2]     = s_tdata[143:128];

    erv_cordic #(
        .ITER (CORDIC_ITERATIONS),
        .W    (VALUE_WIDTH)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .angle     (angle),
        .in_side   (in_side),
        .out_valid (cor_valid),
        .out_ready (cor_ready),
        .sin_o     (cor_sin),
        .cos_o     (cor_cos),
        .out_side  (cor_side)
    );

    erv_matrix #(
        .W (VALUE_WIDTH)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cor_valid),
        .in_ready  (cor_ready),
        .sin_i     (cor_sin),
        .cos_i     (cor_cos),
        .in_side   (cor_side),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .m_o       (mat_m),
        .out_side  (mat_side)
    );

    erv_apply #(
        .W (VALUE_WIDTH)
    ) u_apply (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .m_i       (mat_m),
        .in_side   (mat_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_o     (res)
    );

    assign m_tdata = {res[2], res[1], res[0]};

`ifndef NO_ASSERTIONS
    // a free output end frees the whole ready chain
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled although output side is ready");

    a_cor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cor_valid && !cor_ready |=> cor_valid)
        else $error("cordic beat dropped while matrix stage stalled");

    a_mat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_ready |=> mat_valid && $stable(mat_m))
        else $error("matrix beat lost or changed while stalled");
`endif

endmodule

// ----- hdl/erv_cordic.sv -----
// ---------------------------------------------------------------------------
// erv_cordic
// Three parallel CORDIC pipelines, a quarter-turn fold stage, then one micro-rotation per stage.
// ---------------------------------------------------------------------------
module erv_cordic #(
    parameter int ITER = erv_pkg::CORDIC_ITERATIONS_DEF,
    parameter int W    = erv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0][erv_pkg::ANGLE_W-1:0] angle,
    input  erv_pkg::side_t                in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0][W-1:0]             sin_o,
    output logic [2:0][W-1:0]             cos_o,
    output erv_pkg::side_t                out_side
);

    localparam int N  = ITER + 1;
    localparam int F  = W - 2;
    localparam int ZW = erv_pkg::ZW;
    localparam logic signed [W-1:0] GAIN = W'(erv_pkg::gain_init(F));

    logic [N-1:0]          v_reg;
    logic [N:0]            rdy;
    logic signed [W-1:0]   x_reg    [N][3];
    logic signed [W-1:0]   y_reg    [N][3];
    logic signed [ZW-1:0]  z_reg    [N][3];
    logic [2:0]            flip_reg [N];
    erv_pkg::side_t        side_reg [N];
    logic signed [ZW-1:0]  zin      [3];

    assign rdy[N]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];
    assign out_side  = side_reg[N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            zin[a] = $signed({{(ZW-erv_pkg::ANGLE_W){angle[a][erv_pkg::ANGLE_W-1]}},
                              angle[a]}) <<< 17;
    end

    // quarter-turn fold, then the gain as start value
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            side_reg[0] <= in_side;
            for (int a = 0; a < 3; a++)
            begin
                x_reg[0][a] <= GAIN;
                y_reg[0][a] <= '0;
                if (zin[a] > erv_pkg::HALF_PI_Q30)
                begin
                    z_reg[0][a]    <= zin[a] - erv_pkg::PI_Q30;
                    flip_reg[0][a] <= 1'b1;
                end
                else if (zin[a] < -erv_pkg::HALF_PI_Q30)
                begin
                    z_reg[0][a]    <= zin[a] + erv_pkg::PI_Q30;
                    flip_reg[0][a] <= 1'b1;
                end
                else
                begin
                    z_reg[0][a]    <= zin[a];
                    flip_reg[0][a] <= 1'b0;
                end
            end
        end
    end

    for (genvar k = 1; k < N; k++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = erv_pkg::atan_q30(k - 1);
        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                side_reg[k] <= side_reg[k-1];
                flip_reg[k] <= flip_reg[k-1];
                for (int a = 0; a < 3; a++)
                begin
                    if (z_reg[k-1][a] >= 0)
                    begin
                        x_reg[k][a] <= x_reg[k-1][a] - (y_reg[k-1][a] >>> (k - 1));
                        y_reg[k][a] <= y_reg[k-1][a] + (x_reg[k-1][a] >>> (k - 1));
                        z_reg[k][a] <= z_reg[k-1][a] - ATAN;
                    end
                    else
                    begin
                        x_reg[k][a] <= x_reg[k-1][a] + (y_reg[k-1][a] >>> (k - 1));
                        y_reg[k][a] <= y_reg[k-1][a] - (x_reg[k-1][a] >>> (k - 1));
                        z_reg[k][a] <= z_reg[k-1][a] + ATAN;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sin_o[a] = flip_reg[N-1][a] ? -y_reg[N-1][a] : y_reg[N-1][a];
            cos_o[a] = flip_reg[N-1][a] ? -x_reg[N-1][a] : x_reg[N-1][a];
        end
    end

endmodule

// ----- hdl/erv_matrix.sv -----
// ---------------------------------------------------------------------------
// erv_matrix
// Two-stage build of the roll-pitch-yaw rotation matrix from sines/cosines.
// ---------------------------------------------------------------------------
module erv_matrix #(
    parameter int W = erv_pkg::VALUE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0][W-1:0] sin_i,
    input  logic [2:0][W-1:0] cos_i,
    input  erv_pkg::side_t    in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [8:0][W-1:0] m_o,
    output erv_pkg::side_t    out_side
);

    localparam int F = W - 2;

    function automatic logic signed [W-1:0] cmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W:0] p;
        logic        [2*W:0] m;
        logic        [2*W:0] r;
        p = (2*W+1)'(a) * (2*W+1)'(b);
        m = p[2*W] ? -p : p;
        r = (m + ((2*W+1)'(1) << (F - 1))) >> F;
        return p[2*W] ? -W'(r) : W'(r);
    endfunction

    logic [1:0]          v_reg;
    logic [2:0]          rdy;
    logic signed [W-1:0] sx, cx, sy, cy, sz, cz;
    logic signed [W-1:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, sxcy_reg, cxcy_reg;
    logic signed [W-1:0] cxsz_reg, cxcz_reg, sxsz_reg, sxcz_reg, nsy_reg, cz_reg, sz_reg;
    logic [8:0][W-1:0]   m_reg;
    erv_pkg::side_t      side_a_reg, side_b_reg;

    assign sx = $signed(sin_i[0]);
    assign cx = $signed(cos_i[0]);
    assign sy = $signed(sin_i[1]);
    assign cy = $signed(cos_i[1]);
    assign sz = $signed(sin_i[2]);
    assign cz = $signed(cos_i[2]);

    assign rdy[2]    = out_ready;
    assign rdy[1]    = !v_reg[1] || rdy[2];
    assign rdy[0]    = !v_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[1];
    assign m_o       = m_reg;
    assign out_side  = side_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            if (rdy[1])
                v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            side_a_reg <= in_side;
            sxsy_reg   <= cmul(sx, sy);
            cxsy_reg   <= cmul(cx, sy);
            cycz_reg   <= cmul(cy, cz);
            cysz_reg   <= cmul(cy, sz);
            sxcy_reg   <= cmul(sx, cy);
            cxcy_reg   <= cmul(cx, cy);
            cxsz_reg   <= cmul(cx, sz);
            cxcz_reg   <= cmul(cx, cz);
            sxsz_reg   <= cmul(sx, sz);
            sxcz_reg   <= cmul(sx, cz);
            nsy_reg    <= -sy;
            cz_reg     <= cz;
            sz_reg     <= sz;
        end
    end

    // row-major m00..m22
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            side_b_reg <= side_a_reg;
            m_reg[0]   <= cycz_reg;
            m_reg[1]   <= cysz_reg;
            m_reg[2]   <= nsy_reg;
            m_reg[3]   <= cmul(sxsy_reg, cz_reg) - cxsz_reg;
            m_reg[4]   <= cmul(sxsy_reg, sz_reg) + cxcz_reg;
            m_reg[5]   <= sxcy_reg;
            m_reg[6]   <= cmul(cxsy_reg, cz_reg) + sxsz_reg;
            m_reg[7]   <= cmul(cxsy_reg, sz_reg) - sxcz_reg;
            m_reg[8]   <= cxcy_reg;
        end
    end

endmodule

// ----- hdl/erv_apply.sv -----
// ---------------------------------------------------------------------------
// erv_apply
// Matrix by vector product with rounding, row sums and saturation.
// ---------------------------------------------------------------------------
module erv_apply #(
    parameter int W = erv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [8:0][W-1:0]                 m_i,
    input  erv_pkg::side_t                    in_side,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0][erv_pkg::VEC_W-1:0]    res_o
);

    localparam int F  = W - 2;
    localparam int VW = erv_pkg::VEC_W;
    localparam int PW = erv_pkg::PW;
    localparam int SW = erv_pkg::SW;
    localparam int QW = W + VW + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(64'sd2147483648);

    function automatic logic signed [PW-1:0] vmul(input logic signed [W-1:0]  a,
                                                  input logic signed [VW-1:0] b);
        logic signed [QW-1:0] p;
        logic        [QW-1:0] m;
        logic        [QW-1:0] r;
        p = QW'(a) * QW'(b);
        m = p[QW-1] ? -p : p;
        r = (m + (QW'(1) << (F - 1))) >> F;
        return p[QW-1] ? -PW'(r) : PW'(r);
    endfunction

    logic [1:0]             v_reg;
    logic [2:0]             rdy;
    logic signed [PW-1:0]   p_reg [3][3];
    logic signed [VW-1:0]   vec   [3];
    logic [2:0][VW-1:0]     res_reg;
    logic signed [SW-1:0]   acc   [3];

    assign vec[0] = in_side.vx;
    assign vec[1] = in_side.vy;
    assign vec[2] = in_side.vz;

    assign rdy[2]    = out_ready;
    assign rdy[1]    = !v_reg[1] || rdy[2];
    assign rdy[0]    = !v_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[1];
    assign res_o     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            if (rdy[1])
                v_reg[1] <= v_reg[0];
        end
    end

    // inverse mode reads the matrix transposed
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    p_reg[i][j] <= vmul($signed(in_side.mode ? m_i[j*3+i] : m_i[i*3+j]),
                                        vec[j]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            acc[i] = SW'(p_reg[i][0]) + SW'(p_reg[i][1]) + SW'(p_reg[i][2]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (acc[i] > SAT_HI)
                    res_reg[i] <= SAT_HI[VW-1:0];
                else if (acc[i] < SAT_LO)
                    res_reg[i] <= SAT_LO[VW-1:0];
                else
                    res_reg[i] <= acc[i][VW-1:0];
            end
        end
    end

endmodule

// ----- tb/euler_rotate_vector3_unit_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_rotate_vector3_unit_checker
// Watches both stream channels of the rotator, computes the rotated vector
// for every accepted input beat and compares each output beat against it.
// ---------------------------------------------------------------------------
module euler_rotate_vector3_unit_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    output int           fail_count,
    output int           pending
);

    localparam int FRAC  = 30;
    localparam int ITERS = 16;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
    } rotated_t;

    rotated_t rotated_q[$];

    // product scaled back by 2^FRAC, nearest, ties away from zero
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [63:0]  r;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        p = 128'(ma) * 128'(mb) + (128'd1 << (FRAC - 1));
        r = 64'(p >> FRAC);
        r[63] = 1'b0;
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    task automatic angle_sin_cos(input logic [15:0] ang, output logic signed [63:0] s,
                                 output logic signed [63:0] c);
        logic signed [63:0] z;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic               flip;
        z = 64'($signed(ang)) * 64'sd131072;
        flip = 1'b0;
        // beyond a quarter turn: fold by pi and negate
        if (z > 64'sd1686629713)
        begin
            z = z - 64'sd3373259426;
            flip = 1'b1;
        end
        else if (z < -64'sd1686629713)
        begin
            z = z + 64'sd3373259426;
            flip = 1'b1;
        end
        x = (64'sd42731626434776 + (64'sd1 <<< (45 - FRAC))) >>> (46 - FRAC);
        y = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - 64'(erv_pkg::atan_q30(i));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + 64'(erv_pkg::atan_q30(i));
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    task automatic rotate_vector(input logic [143:0] d, input logic inv, output rotated_t res);
        logic signed [63:0] sx, cx, sy, cy, sz, cz, sxsy, cxsy, acc;
        logic signed [63:0] m [3][3];
        logic signed [63:0] v [3];
        logic signed [31:0] o [3];
        angle_sin_cos(d[111:96], sx, cx);
        angle_sin_cos(d[127:112], sy, cy);
        angle_sin_cos(d[143:128], sz, cz);
        sxsy = scaled_product(sx, sy);
        cxsy = scaled_product(cx, sy);
        m[0][0] = scaled_product(cy, cz);
        m[0][1] = scaled_product(cy, sz);
        m[0][2] = -sy;
        m[1][0] = scaled_product(sxsy, cz) - scaled_product(cx, sz);
        m[1][1] = scaled_product(sxsy, sz) + scaled_product(cx, cz);
        m[1][2] = scaled_product(sx, cy);
        m[2][0] = scaled_product(cxsy, cz) + scaled_product(sx, sz);
        m[2][1] = scaled_product(cxsy, sz) - scaled_product(sx, cz);
        m[2][2] = scaled_product(cx, cy);
        for (int j = 0; j < 3; j++)
            v[j] = 64'($signed(d[j*32 +: 32]));
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc = acc + scaled_product(inv ? m[j][i] : m[i][j], v[j]);
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
            o[i] = acc[31:0];
        end
        res.rx = o[0];
        res.ry = o[1];
        res.rz = o[2];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rotated_t want;
        rotated_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                rotate_vector(s_tdata, s_tuser[0], want);
                rotated_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.rx = m_tdata[31:0];
                got.ry = m_tdata[63:32];
                got.rz = m_tdata[95:64];
                if (rotated_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected output beat %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch x %0d/%0d y %0d/%0d z %0d/%0d (exp/act)",
                                     want.rx, got.rx, want.ry, got.ry, want.rz, got.rz);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= rotated_q.size();
        end
    end

endmodule

// ----- tb/euler_rotate_vector3_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_rotate_vector3_unit_tb
// Drives vectors and roll/pitch/yaw angles into the rotator with random
// gaps and back-pressure; the checker predicts and compares every beat.
// ---------------------------------------------------------------------------
module euler_rotate_vector3_unit_tb;

    localparam int LATENCY     = 21;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BEATS = 1330;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           in_beats;
    int           cycles;
    int           phase;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           held;

    euler_rotate_vector3_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    euler_rotate_vector3_unit_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_beats <= 0;
        else if (s_tvalid && s_tready)
            in_beats <= in_beats + 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("euler_rotate_vector3_unit_tb: errors");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off to fill the pipeline
    initial
    begin
        int hold;
        hold = 0;
        held = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && phase == 2 && in_beats > 700)
            begin
                held = 1;
                hold = 120;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz, input logic [15:0] roll,
                             input logic [15:0] pitch, input logic [15:0] yaw,
                             input logic inv);
        int n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        n = in_beats;
        s_tvalid <= 1'b1;
        s_tdata  <= {yaw, pitch, roll, vz, vy, vx};
        s_tuser  <= inv;
        do
            @(negedge clk);
        while (in_beats == n);
    endtask

    function automatic logic [15:0] rand_angle();
        // mostly in range, now and then any pattern
        if ($urandom_range(15) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(51472)) - 25736);
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(3))
            0:       return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
            1:       return $urandom_range(1) ? 32'h7fffffff - $urandom_range(255)
                                              : 32'h80000000 + $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [15:0] ang [10];
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        phase    = 0;
        send_idle_pct = 6;
        recv_idle_pct = 62;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // angle extremes and the quarter-turn fold boundaries
        ang = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, 16'sd12867,
                -16'sd12868, -16'sd12867, 16'sd32767, -16'sd32768, 16'sd6434};
        send_beat(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_beat(32'h00010000, 32'h00020000, 32'hffff0000, 16'd0, 16'd0, 16'd0, 1'b0);
        for (int i = 1; i < 10; i++)
        begin
            send_beat(32'h00010000, 32'h00030000, 32'hfffe0000, ang[i], ang[(i+3)%10],
                      ang[(i+6)%10], i[0]);
        end
        // saturation at both ends, then all-ones and alternating bit patterns
        send_beat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'sd6434, 16'sd3000,
                  16'sd6434, 1'b0);
        send_beat(32'h80000000, 32'h80000000, 32'h80000000, 16'sd6434, -16'sd3000,
                  16'sd6434, 1'b1);
        send_beat(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'sd25736, 16'sd12868,
                  -16'sd25736, 1'b0);
        send_beat(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff,
                  16'hffff, 1'b1);
        send_beat(32'h55555555, 32'haaaaaaaa, 32'h55555555, 16'h5555, 16'haaaa,
                  16'h5555, 1'b0);
        send_beat(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 16'haaaa, 16'h5555,
                  16'haaaa, 1'b1);

        // let the pipeline drain completely before going on
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);

        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k == RANDOM_BEATS / 3)
            begin
                phase = 1;
                send_idle_pct = 62;
                recv_idle_pct = 6;
            end
            else if (k == 2 * RANDOM_BEATS / 3)
            begin
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_beat(rand_comp(), rand_comp(), rand_comp(), rand_angle(), rand_angle(),
                      rand_angle(), 1'($urandom));
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0)
            $display("euler_rotate_vector3_unit_tb: clean");
        else
            $display("euler_rotate_vector3_unit_tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/erv_pkg.sv
hdl/erv_cordic.sv
hdl/erv_matrix.sv
hdl/erv_apply.sv
hdl/euler_rotate_vector3_unit.sv
tb/euler_rotate_vector3_unit_checker.sv
tb/euler_rotate_vector3_unit_tb.sv
